// ===== sv/sebp_pkg.sv =====
// Shared codes and constants of the serial EEPROM bit protocol core.
package sebp_pkg;

  // Bus access kinds carried in the action field
  localparam logic [2:0] ACT_WRITE_BIT   = 3'd0;
  localparam logic [2:0] ACT_READ_BIT    = 3'd1;
  localparam logic [2:0] ACT_DMA_HINT    = 3'd2;
  localparam logic [2:0] ACT_CLEAR_DIRTY = 3'd3;
  localparam logic [2:0] ACT_RESET_PROTO = 3'd4;

  // Device size codes
  localparam logic [1:0] SIZE_AUTO = 2'd0;
  localparam logic [1:0] SIZE_4K   = 2'd1;
  localparam logic [1:0] SIZE_64K  = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam int unsigned BufBits   = 81;
  localparam int unsigned BlockBits = 64;

  // Bit counts of the command frames
  localparam logic [6:0] LEN_WR_4K  = 7'd73;
  localparam logic [6:0] LEN_WR_64K = 7'd81;
  localparam logic [6:0] LEN_RD_4K  = 7'd9;
  localparam logic [6:0] LEN_RD_64K = 7'd17;
  localparam logic [6:0] HDR_4K     = 7'd8;
  localparam logic [6:0] HDR_64K    = 7'd16;
  localparam logic [6:0] REPLY_PAD  = 7'd4;
  localparam logic [6:0] REPLY_LEN  = 7'd68;

  localparam logic [15:0] DMA_RD_4K  = 16'd9;
  localparam logic [15:0] DMA_WR_4K  = 16'd73;
  localparam logic [15:0] DMA_RD_64K = 16'd17;
  localparam logic [15:0] DMA_WR_64K = 16'd81;

endpackage

// ===== sv/serial_eeprom_bit_protocol_core.sv =====
// Top level of the bit-serial save EEPROM protocol core.
//
//  channel  | dir | payload                                              | transfer when
//  s_axis   | in  | tdata[2:0] action, [3] bit_value, [19:4] dma_count  | tvalid & tready
//  m_axis   | out | tdata[0] read_bit, [1] dirty_flag, [3:2] current_size | tvalid & tready
//  size_mode| in  | size_mode_i                                          | size_mode_we_i
//
//  One item per cycle while s_axis_tready is high: each access updates the control
//  registers; the block RAM is read when a read command opens and its registered data
//  serves the reply bits. After reset a clearing pass fills the block RAM with ones, with
//  s_axis_tready low while it runs. Results go through a two-entry output stage, so one
//  item is still taken while a result waits; s_axis_tready drops when both entries are full.
module serial_eeprom_bit_protocol_core
  import sebp_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        size_mode_we_i,
  input  logic [1:0]  size_mode_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [2:0] action, [3] bit_value, [19:4] dma_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] read_bit, [1] dirty_flag, [3:2] current_size
);

  localparam int unsigned AW = $clog2(BLOCK_COUNT);

  // Protocol state
  logic [BufBits-1:0] buf_q, buf_d;
  logic [6:0]         cnt_q, cnt_d;
  logic               rd_act_q, rd_act_d;
  logic [6:0]         ridx_q, ridx_d;
  logic               oob_q, oob_d;
  logic [15:0]        dma_q, dma_d;
  logic [1:0]         size_q, size_d;
  logic               dirty_q, dirty_d;

  // Clearing pass
  logic               clr_busy_q;
  logic [AW-1:0]      clr_addr_q;

  // Output stage
  logic               out_vld_q, skid_vld_q;
  logic [3:0]         out_q, skid_q;
  logic [3:0]         res;
  logic               pop;

  // Block RAM
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [BlockBits-1:0] mem_wdata, mem_rdata;

  logic        in_acc;
  logic [2:0]  in_action;
  logic        in_bit;
  logic [15:0] in_dma;

  assign in_action = s_axis_tdata[2:0];
  assign in_bit    = s_axis_tdata[3];
  assign in_dma    = s_axis_tdata[19:4];

  assign s_axis_tready = !clr_busy_q && !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_vld_q && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q};

  // Address fields, MSB first from buffer bit 2
  function automatic logic [9:0] addr_4k(input logic [BufBits-1:0] b);
    logic [9:0] a;
    a = '0;
    for (int i = 0; i < 6; i++) begin
      a[5-i] = b[2+i];
    end
    return a;
  endfunction

  function automatic logic [9:0] addr_64k(input logic [BufBits-1:0] b);
    logic [9:0] a;
    a = '0;
    // upper four of the fourteen address bits are masked off
    for (int i = 0; i < 10; i++) begin
      a[9-i] = b[6+i];
    end
    return a;
  endfunction

  function automatic logic [BlockBits-1:0] blk_data(input logic [BufBits-1:0] b,
                                                    input logic            wide);
    logic [BlockBits-1:0] d;
    for (int i = 0; i < BlockBits; i++) begin
      d[BlockBits-1-i] = wide ? b[16+i] : b[8+i];
    end
    return d;
  endfunction

  function automatic logic in_store(input logic [9:0] a);
    return {1'b0, a} < 11'(BLOCK_COUNT);
  endfunction

  always_comb begin
    logic [BufBits-1:0] wb;
    logic [6:0]         wc;
    logic [6:0]         ri;
    logic [5:0]         k;
    logic [9:0]         addr;
    logic               ra;
    logic               roob;
    logic               ab6;
    logic               ab14;
    logic               commit;
    logic               wide;
    logic [BufBits-1:0] cbuf;
    logic               rb;

    buf_d     = buf_q;
    cnt_d     = cnt_q;
    rd_act_d  = rd_act_q;
    ridx_d    = ridx_q;
    oob_d     = oob_q;
    dma_d     = dma_q;
    size_d    = size_q;
    dirty_d   = dirty_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '1;
    mem_re    = 1'b0;
    mem_raddr = '0;
    wb        = buf_q;
    wc        = cnt_q;
    ri        = ridx_q;
    k         = '0;
    addr      = '0;
    ra        = rd_act_q;
    roob      = oob_q;
    ab6       = 1'b0;
    ab14      = 1'b0;
    commit    = 1'b0;
    wide      = 1'b0;
    cbuf      = buf_q;
    rb        = 1'b1;

    if (in_acc) begin
      case (in_action)
        ACT_WRITE_BIT: begin
          // any written bit ends a reply in progress
          if (rd_act_q) begin
            rd_act_d = 1'b0;
            ridx_d   = '0;
            wb       = '0;
            wc       = '0;
          end
          if (!(wc == 7'd0 && !in_bit) && wc < LEN_WR_64K) begin
            wb[wc] = in_bit;
            wc     = wc + 7'd1;
            if (wc >= 7'd2 && !wb[1]) begin
              if (size_q == SIZE_4K && wc == LEN_WR_4K) begin
                commit = 1'b1;
              end else if (size_q == SIZE_64K && wc == LEN_WR_64K) begin
                commit = 1'b1;
                wide   = 1'b1;
              end else if (size_q == SIZE_AUTO) begin
                if (dma_q == DMA_WR_4K && wc == LEN_WR_4K) begin
                  size_d = SIZE_4K;
                  commit = 1'b1;
                end else if (wc == LEN_WR_64K) begin
                  size_d = SIZE_64K;
                  commit = 1'b1;
                  wide   = 1'b1;
                end
              end
            end
          end
          buf_d = wb;
          cnt_d = wc;
          cbuf  = wb;
        end
        ACT_READ_BIT: begin
          if (cnt_q == LEN_WR_4K && !buf_q[1]) begin
            // a 4K write frame is completed by the read access
            size_d = SIZE_4K;
            commit = 1'b1;
          end else begin
            if (!rd_act_q && cnt_q >= 7'd2 && buf_q[1]) begin
              if (cnt_q == LEN_RD_4K || dma_q == DMA_RD_4K || size_q == SIZE_4K) begin
                ab6    = 1'b1;
                size_d = SIZE_4K;
              end else if (cnt_q == LEN_RD_64K || dma_q == DMA_RD_64K ||
                           size_q == SIZE_64K) begin
                ab14   = 1'b1;
                size_d = SIZE_64K;
              end
              if ((ab6 && cnt_q >= HDR_4K) || (ab14 && cnt_q >= HDR_64K)) begin
                addr      = ab6 ? addr_4k(buf_q) : addr_64k(buf_q);
                roob      = !in_store(addr);
                mem_re    = !roob;
                mem_raddr = addr[AW-1:0];
                ra        = 1'b1;
                ri        = '0;
                buf_d     = '0;
                cnt_d     = '0;
                dma_d     = '0;
                oob_d     = roob;
              end
            end
            if (ra) begin
              rd_act_d = 1'b1;
              if (ri < REPLY_PAD) begin
                ridx_d = ri + 7'd1;
                rb     = 1'b0;
              end else if (ri < REPLY_LEN) begin
                k  = 6'(ri - REPLY_PAD);
                // block data comes from the RAM read register loaded at the start access
                rb = roob ? 1'b1 : mem_rdata[6'd63 - k];
                if (ri + 7'd1 >= REPLY_LEN) begin
                  rd_act_d = 1'b0;
                  ridx_d   = '0;
                end else begin
                  ridx_d = ri + 7'd1;
                end
              end else begin
                rd_act_d = 1'b0;
                ridx_d   = '0;
              end
            end
          end
        end
        ACT_DMA_HINT: begin
          dma_d = in_dma;
          if (in_dma == DMA_RD_4K || in_dma == DMA_WR_4K) begin
            if (size_q == SIZE_AUTO) begin
              size_d = SIZE_4K;
            end
          end else if (in_dma == DMA_RD_64K || in_dma == DMA_WR_64K) begin
            size_d = SIZE_64K;
          end
        end
        ACT_CLEAR_DIRTY: begin
          dirty_d = 1'b0;
        end
        ACT_RESET_PROTO: begin
          rd_act_d = 1'b0;
          ridx_d   = '0;
          oob_d    = 1'b0;
          buf_d    = '0;
          cnt_d    = '0;
          dma_d    = '0;
        end
        default: begin
        end
      endcase

      if (commit) begin
        addr = wide ? addr_64k(cbuf) : addr_4k(cbuf);
        if (in_store(addr)) begin
          mem_we    = 1'b1;
          mem_waddr = addr[AW-1:0];
          mem_wdata = blk_data(cbuf, wide);
          dirty_d   = 1'b1;
        end
        buf_d = '0;
        cnt_d = '0;
        dma_d = '0;
      end
    end

    if (size_mode_we_i) begin
      size_d = (size_mode_i == SIZE_BAD) ? SIZE_AUTO : size_mode_i;
    end

    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '1;
    end

    res = {size_d, dirty_d, rb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      cnt_q    <= '0;
      rd_act_q <= 1'b0;
      ridx_q   <= '0;
      oob_q    <= 1'b0;
      dma_q    <= '0;
      size_q   <= SIZE_AUTO;
      dirty_q  <= 1'b0;
    end else begin
      buf_q    <= buf_d;
      cnt_q    <= cnt_d;
      rd_act_q <= rd_act_d;
      ridx_q   <= ridx_d;
      oob_q    <= oob_d;
      dma_q    <= dma_d;
      size_q   <= size_d;
      dirty_q  <= dirty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(BLOCK_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  sebp_ram #(
    .WIDTH (BlockBits),
    .DEPTH (BLOCK_COUNT)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== sv/sebp_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module sebp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/sebp_checker.sv =====
// Port-level assertions for the serial EEPROM bit protocol core, with its bind.
module sebp_checker
  import sebp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // the block RAM clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // an item taken into an empty output stage shows its result next cycle
  a_result_appears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("result missing after transfer");

  a_clear_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !m_axis_tvalid && s_axis_tdata[2:0] == ACT_CLEAR_DIRTY)
      |=> !m_axis_tdata[1])
    else $error("dirty flag not cleared");

  a_dma_64k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !m_axis_tvalid && s_axis_tdata[2:0] == ACT_DMA_HINT &&
     s_axis_tdata[19:4] == DMA_WR_64K) |=> m_axis_tdata[3:2] == SIZE_64K)
    else $error("64K hint did not fix the size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind serial_eeprom_bit_protocol_core sebp_checker u_sebp_checker (.*);

// ===== tb/sv/sebp_status_checker.sv =====
`timescale 1ns / 100ps
// Status checker: predicts the status of every access transfer and compares the output stream.
module sebp_status_checker
  import sebp_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        size_mode_we_i,
  input  logic [1:0]  size_mode_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [2:0] action, [3] bit_value, [19:4] dma_count
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [0] read_bit, [1] dirty_flag, [3:2] current_size
  output int unsigned pending_o,
  output int unsigned fails_o,
  output int unsigned checked_o
);

  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] dma_count;
    logic        bit_value;
    logic [2:0]  action;
  } access_t;

  typedef struct packed {
    logic [3:0] pad;
    logic [1:0] current_size;
    logic       dirty_flag;
    logic       read_bit;
  } status_t;

  // Predicted device state
  logic [63:0]        blk_mem [BLOCK_COUNT];
  logic [0:BufBits-1] frame;
  int unsigned        frame_len;
  logic               reply_on;
  int unsigned        reply_pos;
  logic [9:0]         reply_addr;
  logic [15:0]        dma_len;
  logic [1:0]         size_now;
  logic               dirty;

  status_t     status_due_q[$];
  int unsigned fail_cnt;
  int unsigned check_cnt;

  function automatic void clear_frame();
    frame     = '0;
    frame_len = 0;
  endfunction

  // hdr is 8 for 4K frames and 16 for 64K frames
  function automatic void commit_block(input int unsigned hdr);
    logic [9:0]  addr;
    logic [63:0] data;
    addr = '0;
    data = '0;
    for (int unsigned i = 2; i < hdr; i++) addr = {addr[8:0], frame[i]};
    for (int unsigned i = 0; i < BlockBits; i++) data = {data[62:0], frame[hdr + i]};
    if (addr < BLOCK_COUNT) begin
      blk_mem[addr] = data;
      dirty         = 1'b1;
    end
    clear_frame();
    dma_len = '0;
  endfunction

  function automatic void shift_in_bit(input logic b);
    if (reply_on) begin
      reply_on  = 1'b0;
      reply_pos = 0;
      clear_frame();
    end
    // leading zeros are dropped, and a full buffer takes nothing more
    if (frame_len == 0 && !b) return;
    if (frame_len >= BufBits) return;
    frame[frame_len] = b;
    frame_len++;
    if (frame_len >= 2 && !frame[1]) begin
      if (size_now == SIZE_4K && frame_len == LEN_WR_4K) begin
        commit_block(HDR_4K);
      end else if (size_now == SIZE_64K && frame_len == LEN_WR_64K) begin
        commit_block(HDR_64K);
      end else if (size_now == SIZE_AUTO) begin
        if (dma_len == DMA_WR_4K && frame_len == LEN_WR_4K) begin
          size_now = SIZE_4K;
          commit_block(HDR_4K);
        end else if (frame_len == LEN_WR_64K) begin
          size_now = SIZE_64K;
          commit_block(HDR_64K);
        end
      end
    end
  endfunction

  function automatic logic shift_out_bit();
    int unsigned abits;
    int unsigned k;
    logic [9:0]  addr;
    logic        v;
    // a 73-bit write frame still waiting is taken as 4K on the read access
    if (frame_len == LEN_WR_4K && !frame[1]) begin
      size_now = SIZE_4K;
      commit_block(HDR_4K);
      return 1'b1;
    end
    if (!reply_on && frame_len >= 2 && frame[1]) begin
      abits = 0;
      if (frame_len == LEN_RD_4K || dma_len == DMA_RD_4K || size_now == SIZE_4K) begin
        abits    = 6;
        size_now = SIZE_4K;
      end else if (frame_len == LEN_RD_64K || dma_len == DMA_RD_64K ||
                   size_now == SIZE_64K) begin
        abits    = 14;
        size_now = SIZE_64K;
      end
      if (abits > 0 && frame_len >= 2 + abits) begin
        addr = '0;
        for (int unsigned i = 2; i < 2 + abits; i++) addr = {addr[8:0], frame[i]};
        reply_addr = addr;
        reply_on   = 1'b1;
        reply_pos  = 0;
        clear_frame();
        dma_len = '0;
      end
    end
    if (reply_on) begin
      if (reply_pos < REPLY_PAD) begin
        reply_pos++;
        return 1'b0;
      end
      k = reply_pos - REPLY_PAD;
      if (k < BlockBits) begin
        v = 1'b1;
        if (reply_addr < BLOCK_COUNT) v = blk_mem[reply_addr][63 - k];
        reply_pos++;
        if (reply_pos >= REPLY_LEN) begin
          reply_on  = 1'b0;
          reply_pos = 0;
        end
        return v;
      end
      reply_on  = 1'b0;
      reply_pos = 0;
    end
    return 1'b1;
  endfunction

  function automatic status_t apply_access(input access_t acc);
    status_t st;
    st          = '0;
    st.read_bit = 1'b1;
    case (acc.action)
      ACT_WRITE_BIT: shift_in_bit(acc.bit_value);
      ACT_READ_BIT:  st.read_bit = shift_out_bit();
      ACT_DMA_HINT: begin
        dma_len = acc.dma_count;
        if (acc.dma_count == DMA_RD_4K || acc.dma_count == DMA_WR_4K) begin
          if (size_now == SIZE_AUTO) size_now = SIZE_4K;
        end else if (acc.dma_count == DMA_RD_64K || acc.dma_count == DMA_WR_64K) begin
          size_now = SIZE_64K;
        end
      end
      ACT_CLEAR_DIRTY: dirty = 1'b0;
      ACT_RESET_PROTO: begin
        reply_on   = 1'b0;
        reply_pos  = 0;
        reply_addr = '0;
        clear_frame();
        dma_len = '0;
      end
      default: ;
    endcase
    st.dirty_flag   = dirty;
    st.current_size = size_now;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t want;
    status_t got;
    status_t due;
    if (!rst_ni) begin
      for (int i = 0; i < BLOCK_COUNT; i++) blk_mem[i] = '1;
      clear_frame();
      reply_on   = 1'b0;
      reply_pos  = 0;
      reply_addr = '0;
      dma_len    = '0;
      size_now   = SIZE_AUTO;
      dirty      = 1'b0;
      status_due_q.delete();
      fail_cnt   = 0;
      check_cnt  = 0;
      pending_o <= 0;
      fails_o   <= 0;
      checked_o <= 0;
    end else begin
      if (size_mode_we_i) size_now = (size_mode_i == SIZE_BAD) ? SIZE_AUTO : size_mode_i;
      if (s_axis_tvalid && s_axis_tready) begin
        due          = apply_access(s_axis_tdata);
        status_due_q = {status_due_q, due};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_due_q.size() == 0) begin
          $error("status transfer 0x%02h with nothing expected", got);
          fail_cnt++;
        end else begin
          want = status_due_q.pop_front();
          check_cnt++;
          if (got.read_bit !== want.read_bit) begin
            $error("read_bit: expected %0b, got %0b", want.read_bit, got.read_bit);
            fail_cnt++;
          end
          if (got.dirty_flag !== want.dirty_flag) begin
            $error("dirty_flag: expected %0b, got %0b", want.dirty_flag, got.dirty_flag);
            fail_cnt++;
          end
          if (got.current_size !== want.current_size) begin
            $error("current_size: expected %0d, got %0d", want.current_size,
                   got.current_size);
            fail_cnt++;
          end
        end
      end
      pending_o <= status_due_q.size();
      fails_o   <= fail_cnt;
      checked_o <= check_cnt;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, access stimulus and verdict for the EEPROM protocol core.
module testbench;
  import sebp_pkg::*;

  localparam int unsigned BlockCount = 1024;
  localparam int unsigned PhaseItems = 200;
  localparam logic [2:0]  ACT_SPARE_LO = 3'd5;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        size_mode_we_i = 1'b0;
  logic [1:0]  size_mode_i    = SIZE_AUTO;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata   = '0;   // [2:0] action, [3] bit_value, [19:4] dma_count
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [7:0]  m_axis_tdata;          // [0] read_bit, [1] dirty_flag, [3:2] current_size

  int unsigned pending;
  int unsigned fails;
  int unsigned checked;
  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 83;
  int unsigned items_sent  = 0;
  int unsigned wr_frames   = 0;
  int unsigned rd_frames   = 0;

  serial_eeprom_bit_protocol_core #(
    .BLOCK_COUNT(BlockCount)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .size_mode_we_i,
    .size_mode_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  sebp_status_checker #(
    .BLOCK_COUNT(BlockCount)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .size_mode_we_i,
    .size_mode_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .pending_o (pending),
    .fails_o   (fails),
    .checked_o (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #(3_000_000);
    $display("serial_eeprom_bit_protocol_core verification failed");
    $finish;
  end

  // valid stays high between back-to-back transfers; it only drops on an idle cycle
  task automatic send_access(input logic [2:0] act, input logic bv, input logic [15:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, cnt, bv, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // sends the first cnt bits of an n-bit command, MSB first
  task automatic send_bits(input logic [95:0] v, input int unsigned n, input int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) begin
      send_access(ACT_WRITE_BIT, v[n - 1 - i], 16'($urandom));
    end
  endtask

  task automatic send_reads(input int unsigned cnt);
    repeat (cnt) send_access(ACT_READ_BIT, 1'($urandom), 16'($urandom));
  endtask

  task automatic wait_settled();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_size_mode(input logic [1:0] m);
    wait_settled();
    size_mode_i    <= m;
    size_mode_we_i <= 1'b1;
    @(posedge clk_i);
    size_mode_we_i <= 1'b0;
  endtask

  task automatic run_sequence(input logic [1:0] mode);
    int unsigned pick;
    int unsigned abits;
    int unsigned n;
    int unsigned cut;
    logic [13:0] addr;
    logic [63:0] data;
    logic [95:0] v;
    pick = $urandom_range(99);
    if (mode == SIZE_4K) abits = 6;
    else if (mode == SIZE_64K) abits = 14;
    else abits = $urandom_range(1) ? 14 : 6;
    if ($urandom_range(9) == 0) abits = (abits == 6) ? 14 : 6;
    // a small address set makes read-back of earlier commits likely
    addr = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(7));
    if (pick < 40) begin
      if ($urandom_range(1)) begin
        send_access(ACT_DMA_HINT, 1'($urandom), (abits == 6) ? DMA_WR_4K : DMA_WR_64K);
      end else if ($urandom_range(4) == 0) begin
        send_access(ACT_DMA_HINT, 1'($urandom), 16'($urandom));
      end
      case ($urandom_range(9))
        0:       data = '0;
        1:       data = '1;
        default: data = {$urandom, $urandom};
      endcase
      v = 96'b10;
      v = (v << abits) | 96'(addr & ((14'd1 << abits) - 1));
      v = (v << BlockBits) | 96'(data);
      v = (v << 1) | 96'($urandom_range(1));
      n = 2 + abits + BlockBits + 1;
      cut = ($urandom_range(9) == 0) ? $urandom_range(n - 1, 1) : n;
      send_bits(v, n, cut);
      wr_frames++;
      if (cut < n) begin
        if ($urandom_range(1)) send_reads($urandom_range(3, 1));
        else send_access(ACT_RESET_PROTO, 1'($urandom), 16'($urandom));
      end
    end else if (pick < 75) begin
      if ($urandom_range(1)) begin
        send_access(ACT_DMA_HINT, 1'($urandom), (abits == 6) ? DMA_RD_4K : DMA_RD_64K);
      end
      v = 96'b11;
      v = (v << abits) | 96'(addr & ((14'd1 << abits) - 1));
      v = (v << 1) | 96'($urandom_range(1));
      n = 2 + abits + 1;
      send_bits(v, n, n);
      rd_frames++;
      case ($urandom_range(9))
        0:       send_reads($urandom_range(67, 1));   // cut short: next write ends the reply
        1:       send_reads($urandom_range(72, 69));  // runs past the reply end
        default: send_reads(REPLY_LEN);
      endcase
    end else if (pick < 85) begin
      repeat ($urandom_range(8, 1)) begin
        send_access(3'($urandom), 1'($urandom), 16'($urandom));
      end
    end else if (pick < 90) begin
      // overlong read command fills the bit buffer
      v = {2'b11, 30'($urandom), {$urandom, $urandom}};
      send_bits(v, 96, 96);
      send_reads($urandom_range(REPLY_LEN, 1));
    end else if (pick < 95) begin
      if ($urandom_range(1)) send_access(ACT_CLEAR_DIRTY, 1'($urandom), 16'($urandom));
      else send_access(ACT_RESET_PROTO, 1'($urandom), 16'($urandom));
    end else begin
      // read command of a length that may not fix the address width
      v = {2'b11, 30'($urandom), {$urandom, $urandom}};
      send_bits(v, 96, $urandom_range(14, 2));
      send_reads($urandom_range(2, 1));
      send_access(ACT_RESET_PROTO, 1'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [1:0]  size_plan [6];
    int unsigned goal;
    size_plan[0] = SIZE_4K;
    size_plan[1] = SIZE_AUTO;
    size_plan[2] = SIZE_64K;
    size_plan[3] = SIZE_BAD;
    size_plan[4] = SIZE_AUTO;
    size_plan[5] = SIZE_64K;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every action, the odd corners
    send_access(ACT_WRITE_BIT, 1'b0, 16'hFFFF);      // leading zero, dropped
    send_access(ACT_DMA_HINT, 1'b1, 16'h0000);
    send_access(ACT_DMA_HINT, 1'b0, 16'hFFFF);
    for (logic [2:0] a = ACT_SPARE_LO; a <= ACT_SPARE_HI && a != 3'd0; a++) begin
      send_access(a, 1'($urandom), 16'($urandom));
    end
    send_access(ACT_CLEAR_DIRTY, 1'b1, 16'h0000);
    send_bits(96'b11101, 5, 5);                       // read command, width still unknown
    send_reads(1);
    send_access(ACT_DMA_HINT, 1'b0, DMA_RD_64K);
    send_reads(1);                                    // too few address bits yet
    send_access(ACT_RESET_PROTO, 1'b1, 16'hFFFF);
    send_access(ACT_DMA_HINT, 1'b1, DMA_WR_4K);       // no size change once the size is fixed
    send_access(ACT_DMA_HINT, 1'b0, DMA_WR_64K);
    send_access(ACT_WRITE_BIT, 1'b1, 16'h0000);
    send_reads(1);
    send_access(ACT_WRITE_BIT, 1'b0, 16'hFFFF);
    send_access(ACT_RESET_PROTO, 1'b0, 16'h0000);
    load_size_mode(SIZE_BAD);                          // code three means autodetect
    send_access(ACT_DMA_HINT, 1'b1, DMA_RD_4K);
    send_access(ACT_CLEAR_DIRTY, 1'b0, 16'hFFFF);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0:       begin tx_idle_pct = 23; rx_idle_pct = 83; end
        1:       begin tx_idle_pct = 83; rx_idle_pct = 23; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      load_size_mode(size_plan[ph]);
      goal = items_sent + PhaseItems;
      while (items_sent < goal) run_sequence(size_plan[ph]);
    end

    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < 20000 && pending != 0; k++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (pending != 0) $error("%0d status transfers never arrived", pending);
    $display("Sent %0d access transfers: %0d write commands, %0d read commands; %0d checked",
             items_sent, wr_frames, rd_frames, checked);
    $display("Sizes 4K, 64K, autodetect and code three, under three stall mixes");
    if (fails == 0 && pending == 0) begin
      $display("serial_eeprom_bit_protocol_core verification clean");
    end else begin
      $display("serial_eeprom_bit_protocol_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sebp_pkg.sv
sv/sebp_ram.sv
sv/serial_eeprom_bit_protocol_core.sv
sv/sebp_checker.sv
tb/sv/sebp_status_checker.sv
tb/sv/testbench.sv
